// ===== hw/rtl/lbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared widths, reset values, register codes and types of the letterbox
// resize address generator.
// ----------------------------------------------------------------------------
package lbr_pkg;

  // Field widths
  localparam int unsigned DimW     = 13;  // frame dimensions
  localparam int unsigned CoordW   = 12;  // pixel coordinates
  localparam int unsigned BppW     = 3;   // bytes per pixel
  localparam int unsigned PadW     = 11;  // reported pad sizes
  localparam int unsigned OffW     = 26;  // byte offsets
  localparam int unsigned PW       = 2 * DimW;  // products of two dimensions
  localparam int unsigned QW       = DimW;      // quotient bits of the scale
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  // Quotient bits resolved per pipeline stage
  localparam int unsigned DivBits  = 3;

  // Default limits
  localparam int unsigned MaxDim      = 4096;
  localparam int unsigned MaxChannels = 4;

  // Register reset values
  localparam logic [DimW-1:0] RstSrcW = DimW'(1920);
  localparam logic [DimW-1:0] RstSrcH = DimW'(1080);
  localparam logic [DimW-1:0] RstDstW = DimW'(640);
  localparam logic [DimW-1:0] RstDstH = DimW'(640);
  localparam logic [BppW-1:0] RstBpp  = BppW'(3);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_DST_W = 3'd2,
    REG_DST_H = 3'd3,
    REG_BPP   = 3'd4
  } lbr_reg_e;

  // Geometry sequencer states
  typedef enum logic [2:0] {
    SETUP_CLAMP,
    SETUP_MUL,
    SETUP_SEL,
    SETUP_PROD,
    SETUP_DIV,
    SETUP_PAD,
    SETUP_DONE
  } lbr_setup_e;

  // Frame geometry handed from the sequencer to the pixel pipeline
  typedef struct packed {
    logic            valid;
    logic [DimW-1:0] sw;
    logic [DimW-1:0] sh;
    logic [DimW-1:0] tw;
    logic [DimW-1:0] th;
    logic [BppW-1:0] bpp;
    logic [DimW-1:0] num;
    logic [DimW-1:0] den;
    logic [DimW-1:0] cw;
    logic [DimW-1:0] ch;
    logic [DimW-1:0] padl;
    logic [DimW-1:0] padt;
  } lbr_geo_t;

endpackage

// ===== hw/rtl/lbr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lbr_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface lbr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lbr_pkg::CfgIdxW-1:0]  index;
  logic [lbr_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/lbr_in_if.sv =====
// ----------------------------------------------------------------------------
// lbr_in_if
// Destination pixel coordinate channel with valid/ready.
// ----------------------------------------------------------------------------
interface lbr_in_if;
  logic                       valid;
  logic                       ready;
  logic [lbr_pkg::CoordW-1:0] dest_col;
  logic [lbr_pkg::CoordW-1:0] dest_row;

  modport source (output valid, output dest_col, output dest_row, input ready);
  modport sink   (input valid, input dest_col, input dest_row, output ready);
endinterface

// ===== hw/rtl/lbr_out_if.sv =====
// ----------------------------------------------------------------------------
// lbr_out_if
// Address result channel with valid/ready.
// ----------------------------------------------------------------------------
interface lbr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       is_pad;
  logic                       bad_coord;
  logic [lbr_pkg::CoordW-1:0] source_col;
  logic [lbr_pkg::CoordW-1:0] source_row;
  logic [lbr_pkg::OffW-1:0]   source_offset;
  logic [lbr_pkg::OffW-1:0]   dest_offset;
  logic [lbr_pkg::PadW-1:0]   pad_left;
  logic [lbr_pkg::PadW-1:0]   pad_top;
  logic [lbr_pkg::DimW-1:0]   content_width;
  logic [lbr_pkg::DimW-1:0]   content_height;
  logic [lbr_pkg::DimW-1:0]   ratio_num;
  logic [lbr_pkg::DimW-1:0]   ratio_den;

  modport source (
    output valid, output is_pad, output bad_coord, output source_col,
    output source_row, output source_offset, output dest_offset,
    output pad_left, output pad_top, output content_width,
    output content_height, output ratio_num, output ratio_den,
    input ready
  );
  modport sink (
    input valid, input is_pad, input bad_coord, input source_col,
    input source_row, input source_offset, input dest_offset,
    input pad_left, input pad_top, input content_width,
    input content_height, input ratio_num, input ratio_den,
    output ready
  );
endinterface

// ===== hw/rtl/lbr_div_stage.sv =====
// ----------------------------------------------------------------------------
// lbr_div_stage
// A few restoring division steps: resolves quotient bits TopBit down to
// TopBit-Steps+1 of rem_i / divisor_i. Bits below zero pass through.
// ----------------------------------------------------------------------------
module lbr_div_stage #(
  parameter int Steps  = 3,
  parameter int TopBit = 12
) (
  input  logic [lbr_pkg::DimW-1:0] divisor_i,
  input  logic [lbr_pkg::PW-1:0]   rem_i,
  input  logic [lbr_pkg::QW-1:0]   quo_i,
  output logic [lbr_pkg::PW-1:0]   rem_o,
  output logic [lbr_pkg::QW-1:0]   quo_o
);

  logic [lbr_pkg::PW-1:0] rem_w [Steps+1];
  logic [lbr_pkg::QW-1:0] quo_w [Steps+1];

  assign rem_w[0] = rem_i;
  assign quo_w[0] = quo_i;

  // Chain of compare-and-subtract steps against the shifted divisor
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Bit = TopBit - k;
    if (Bit >= 0) begin : g_live
      logic [lbr_pkg::PW-1:0] shifted;
      assign shifted = lbr_pkg::PW'(divisor_i) << Bit;
      always_comb begin
        rem_w[k+1] = rem_w[k];
        quo_w[k+1] = quo_w[k];
        if (rem_w[k] >= shifted) begin
          rem_w[k+1]      = rem_w[k] - shifted;
          quo_w[k+1][Bit] = 1'b1;
        end
      end
    end else begin : g_pass
      assign rem_w[k+1] = rem_w[k];
      assign quo_w[k+1] = quo_w[k];
    end
  end

  assign rem_o = rem_w[Steps];
  assign quo_o = quo_w[Steps];

endmodule

// ===== hw/rtl/lbr_setup.sv =====
// ----------------------------------------------------------------------------
// lbr_setup
// Configuration registers and frame geometry sequencer: clamps the
// dimensions, picks the scale ratio and divides out content size and pads.
// ----------------------------------------------------------------------------
module lbr_setup #(
  parameter int unsigned MaxDim      = lbr_pkg::MaxDim,
  parameter int unsigned MaxChannels = lbr_pkg::MaxChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lbr_cfg_if.sink           cfg_i,
  output lbr_pkg::lbr_geo_t geo_o
);

  localparam int unsigned DimW = lbr_pkg::DimW;
  localparam int unsigned PW   = lbr_pkg::PW;
  localparam int unsigned QW   = lbr_pkg::QW;
  localparam int unsigned CntW = $clog2(QW);

  lbr_pkg::lbr_setup_e state_q, state_d;

  logic [DimW-1:0]          src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [lbr_pkg::BppW-1:0] bpp_raw_q;

  logic [DimW-1:0]          sw_q, sh_q, tw_q, th_q, num_q, den_q;
  logic [DimW-1:0]          cw_q, ch_q, padl_q, padt_q, cw_acc_q, ch_acc_q;
  logic [lbr_pkg::BppW-1:0] bpp_q;
  logic [PW-1:0]            prod_a_q, prod_b_q, rem_w_q, rem_h_q;
  logic [CntW-1:0]          cnt_q;

  logic cfg_wr;
  logic ld_clamp, ld_mul, ld_sel, ld_prod, div_en, ld_pad, done;

  logic [DimW-1:0] sw_c, sh_c, tw_c, th_c, cw_sat, ch_sat;
  logic [lbr_pkg::BppW-1:0] bpp_c;
  logic [PW-1:0] den_sh;

  // Clamp a dimension register into its legal range
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > MaxDim) begin
      r = DimW'(MaxDim);
    end
    return r;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= lbr_pkg::RstSrcW;
      src_h_q   <= lbr_pkg::RstSrcH;
      dst_w_q   <= lbr_pkg::RstDstW;
      dst_h_q   <= lbr_pkg::RstDstH;
      bpp_raw_q <= lbr_pkg::RstBpp;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        lbr_pkg::REG_SRC_W: src_w_q   <= cfg_i.data;
        lbr_pkg::REG_SRC_H: src_h_q   <= cfg_i.data;
        lbr_pkg::REG_DST_W: dst_w_q   <= cfg_i.data;
        lbr_pkg::REG_DST_H: dst_h_q   <= cfg_i.data;
        lbr_pkg::REG_BPP:   bpp_raw_q <= cfg_i.data[lbr_pkg::BppW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp register values
  always_comb begin
    sw_c  = clamp_dim(src_w_q);
    sh_c  = clamp_dim(src_h_q);
    tw_c  = clamp_dim(dst_w_q);
    th_c  = clamp_dim(dst_h_q);
    bpp_c = bpp_raw_q;
    if (bpp_raw_q == '0) begin
      bpp_c = lbr_pkg::BppW'(1);
    end else if (32'(bpp_raw_q) > MaxChannels) begin
      bpp_c = lbr_pkg::BppW'(MaxChannels);
    end
  end

  // Next state: any register write restarts the sequence
  always_comb begin
    state_d = state_q;
    if (cfg_wr) begin
      state_d = lbr_pkg::SETUP_CLAMP;
    end else begin
      case (state_q)
        lbr_pkg::SETUP_CLAMP: state_d = lbr_pkg::SETUP_MUL;
        lbr_pkg::SETUP_MUL:   state_d = lbr_pkg::SETUP_SEL;
        lbr_pkg::SETUP_SEL:   state_d = lbr_pkg::SETUP_PROD;
        lbr_pkg::SETUP_PROD:  state_d = lbr_pkg::SETUP_DIV;
        lbr_pkg::SETUP_DIV: begin
          if (cnt_q == '0) state_d = lbr_pkg::SETUP_PAD;
        end
        lbr_pkg::SETUP_PAD:   state_d = lbr_pkg::SETUP_DONE;
        lbr_pkg::SETUP_DONE:  state_d = lbr_pkg::SETUP_DONE;
        default:              state_d = lbr_pkg::SETUP_CLAMP;
      endcase
    end
  end

  // Outputs: datapath load strobes per state
  always_comb begin
    ld_clamp = 1'b0;
    ld_mul   = 1'b0;
    ld_sel   = 1'b0;
    ld_prod  = 1'b0;
    div_en   = 1'b0;
    ld_pad   = 1'b0;
    done     = 1'b0;
    case (state_q)
      lbr_pkg::SETUP_CLAMP: ld_clamp = 1'b1;
      lbr_pkg::SETUP_MUL:   ld_mul   = 1'b1;
      lbr_pkg::SETUP_SEL:   ld_sel   = 1'b1;
      lbr_pkg::SETUP_PROD:  ld_prod  = 1'b1;
      lbr_pkg::SETUP_DIV:   div_en   = 1'b1;
      lbr_pkg::SETUP_PAD:   ld_pad   = 1'b1;
      lbr_pkg::SETUP_DONE:  done     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbr_pkg::SETUP_CLAMP;
    end else begin
      state_q <= state_d;
    end
  end

  // Shifted divisor and saturated content sizes
  assign den_sh = PW'(den_q) << cnt_q;
  assign cw_sat = (cw_acc_q > tw_q) ? tw_q : cw_acc_q;
  assign ch_sat = (ch_acc_q > th_q) ? th_q : ch_acc_q;

  // Geometry datapath
  always_ff @(posedge clk_i) begin
    if (ld_clamp) begin
      sw_q  <= sw_c;
      sh_q  <= sh_c;
      tw_q  <= tw_c;
      th_q  <= th_c;
      bpp_q <= bpp_c;
    end
    if (ld_mul) begin
      prod_a_q <= PW'(tw_q) * PW'(sh_q);
      prod_b_q <= PW'(th_q) * PW'(sw_q);
    end
    if (ld_sel) begin
      if (prod_a_q < prod_b_q) begin
        num_q <= tw_q;
        den_q <= sw_q;
      end else begin
        num_q <= th_q;
        den_q <= sh_q;
      end
    end
    if (ld_prod) begin
      rem_w_q  <= PW'(sw_q) * PW'(num_q);
      rem_h_q  <= PW'(sh_q) * PW'(num_q);
      cw_acc_q <= '0;
      ch_acc_q <= '0;
      cnt_q    <= CntW'(QW - 1);
    end
    // One quotient bit of both content sizes per cycle
    if (div_en) begin
      if (rem_w_q >= den_sh) begin
        rem_w_q         <= rem_w_q - den_sh;
        cw_acc_q[cnt_q] <= 1'b1;
      end
      if (rem_h_q >= den_sh) begin
        rem_h_q         <= rem_h_q - den_sh;
        ch_acc_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - 1'b1;
    end
    if (ld_pad) begin
      cw_q   <= cw_sat;
      ch_q   <= ch_sat;
      padl_q <= (tw_q - cw_sat) >> 1;
      padt_q <= (th_q - ch_sat) >> 1;
    end
  end

  // Assemble geometry for the pixel pipeline
  always_comb begin
    geo_o.valid = done;
    geo_o.sw    = sw_q;
    geo_o.sh    = sh_q;
    geo_o.tw    = tw_q;
    geo_o.th    = th_q;
    geo_o.bpp   = bpp_q;
    geo_o.num   = num_q;
    geo_o.den   = den_q;
    geo_o.cw    = cw_q;
    geo_o.ch    = ch_q;
    geo_o.padl  = padl_q;
    geo_o.padt  = padt_q;
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> state_q == lbr_pkg::SETUP_CLAMP)
    else $error("geometry sequence did not restart after a register write");

  a_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (cw_q <= tw_q) && (ch_q <= th_q))
    else $error("content region exceeds destination frame");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (cw_q == num_q) || (ch_q == num_q))
    else $error("neither content side matches the chosen target dimension");
`endif

endmodule

// ===== hw/rtl/letterbox_resize_address_gen.sv =====
// ----------------------------------------------------------------------------
// letterbox_resize_address_gen
// Letterbox nearest-neighbor address generator: per destination pixel,
// padding/content decision, source coordinate and byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  register writes (source/target width and height, bytes per pixel).
//          Always ready. Each write restarts the geometry sequence, which
//          holds pix_i.ready low while it recomputes the scale, content size
//          and pads (one quotient bit per cycle over 13 bits).
//   pix_i  destination coordinates, one item per cycle when not stalled.
//   res_o  one result item per coordinate, in order.
// Throughput is one item per cycle while res_o is ready and the geometry is
// settled, set by the eleven-stage pipeline whose source-coordinate divider
// resolves three quotient bits per stage.
// After reset the registers hold their defaults and the geometry sequence
// runs once before the first item is taken.
// When res_o stalls, each stage holds its item; empty stages still fill, so
// input items are accepted until the pipeline is full.
// ----------------------------------------------------------------------------
module letterbox_resize_address_gen #(
  parameter int unsigned MaxDim      = lbr_pkg::MaxDim,
  parameter int unsigned MaxChannels = lbr_pkg::MaxChannels
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbr_cfg_if.sink   cfg_i,
  lbr_in_if.sink    pix_i,
  lbr_out_if.source res_o
);

  localparam int unsigned DimW    = lbr_pkg::DimW;
  localparam int unsigned CoordW  = lbr_pkg::CoordW;
  localparam int unsigned PW      = lbr_pkg::PW;
  localparam int unsigned QW      = lbr_pkg::QW;
  localparam int unsigned OffW    = lbr_pkg::OffW;
  localparam int unsigned BppW    = lbr_pkg::BppW;
  localparam int unsigned DivBits = lbr_pkg::DivBits;
  localparam int unsigned ND      = (QW + DivBits - 1) / DivBits;

  // Stage positions
  localparam int unsigned S1  = 0;
  localparam int unsigned S2  = 1;
  localparam int unsigned SD0 = 2;
  localparam int unsigned SCL = SD0 + ND;
  localparam int unsigned SM  = SCL + 1;
  localparam int unsigned SA  = SM + 1;
  localparam int unsigned SO  = SA + 1;
  localparam int unsigned NSt = SO + 1;

  typedef struct packed {
    logic              bad;
    logic              pad;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] xc;
    logic [CoordW-1:0] xr;
  } s1_t;

  typedef struct packed {
    logic              bad;
    logic              pad;
    logic [CoordW-1:0] col;
    logic [PW-1:0]     pc;
    logic [PW-1:0]     pr;
    logic [PW-1:0]     dprod;
  } s2_t;

  typedef struct packed {
    logic            bad;
    logic            pad;
    logic            ovf_c;
    logic            ovf_r;
    logic [OffW-1:0] doff;
  } side_t;

  typedef struct packed {
    logic            bad;
    logic            pad;
    logic [DimW-1:0] scol;
    logic [DimW-1:0] srow;
    logic [OffW-1:0] doff;
  } cl_t;

  typedef struct packed {
    logic            bad;
    logic            pad;
    logic [DimW-1:0] scol;
    logic [PW-1:0]   sprod;
    logic [OffW-1:0] doff;
  } sm_t;

  typedef struct packed {
    logic            bad;
    logic            pad;
    logic [DimW-1:0] scol;
    logic [PW:0]     ssum;
    logic [OffW-1:0] doff;
  } sa_t;

  typedef struct packed {
    logic            bad;
    logic            pad;
    logic [DimW-1:0] scol;
    logic [DimW-1:0] srow;
    logic [OffW-1:0] soff;
    logic [OffW-1:0] doff;
  } so_t;

  lbr_pkg::lbr_geo_t geo;

  logic [NSt-1:0] v_q, ld;
  logic           pix_acc;

  s1_t  s1_q, s1_d;
  s2_t  s2_q;
  cl_t  cl_q, cl_d;
  sm_t  sm_q;
  sa_t  sa_q;
  so_t  so_q, so_d;

  logic [PW-1:0]   dv_rc_q [ND];
  logic [PW-1:0]   dv_rr_q [ND];
  logic [QW-1:0]   dv_qc_q [ND];
  logic [QW-1:0]   dv_qr_q [ND];
  side_t           dv_side_q [ND];
  logic [PW-1:0]   dsum_q;
  logic [DimW-1:0] srow_m_q, srow_a_q;

  // Geometry sequencer and configuration registers
  lbr_setup #(
    .MaxDim      (MaxDim),
    .MaxChannels (MaxChannels)
  ) u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .geo_o  (geo)
  );

  // Stage load enables: a stage loads when empty or when its item moves on
  always_comb begin
    ld[NSt-1] = !v_q[NSt-1] || res_o.ready;
    for (int k = NSt - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign pix_i.ready = ld[S1] && geo.valid;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[S1]) v_q[S1] <= pix_acc;
      for (int k = 1; k < NSt; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: frame and content region tests, offsets into the content
  always_comb begin
    logic [DimW-1:0] colx, rowx, dxc, dxr;
    logic [DimW:0]   hic, hir;
    logic            padc;
    colx = DimW'(pix_i.dest_col);
    rowx = DimW'(pix_i.dest_row);
    hic  = (DimW+1)'(geo.padl) + (DimW+1)'(geo.cw);
    hir  = (DimW+1)'(geo.padt) + (DimW+1)'(geo.ch);
    padc = (colx < geo.padl) || ((DimW+1)'(colx) >= hic) ||
           (rowx < geo.padt) || ((DimW+1)'(rowx) >= hir);
    dxc  = colx - geo.padl;
    dxr  = rowx - geo.padt;
    s1_d.bad = (colx >= geo.tw) || (rowx >= geo.th);
    s1_d.pad = !s1_d.bad && padc;
    s1_d.col = pix_i.dest_col;
    s1_d.row = pix_i.dest_row;
    s1_d.xc  = dxc[CoordW-1:0];
    s1_d.xr  = dxr[CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld[S1]) s1_q <= s1_d;
  end

  // Stage 2: scale numerators and destination row product
  always_ff @(posedge clk_i) begin
    if (ld[S2]) begin
      s2_q.bad   <= s1_q.bad;
      s2_q.pad   <= s1_q.pad;
      s2_q.col   <= s1_q.col;
      s2_q.pc    <= PW'(s1_q.xc) * PW'(geo.den);
      s2_q.pr    <= PW'(s1_q.xr) * PW'(geo.den);
      s2_q.dprod <= PW'(s1_q.row) * PW'(geo.tw);
    end
  end

  // Divider stages: source coordinate = numerator / ratio_num
  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int Top = int'(QW) - 1 - int'(DivBits) * j;

    logic [PW-1:0] rc_in, rr_in, rc_out, rr_out;
    logic [QW-1:0] qc_in, qr_in, qc_out, qr_out;
    side_t         side_d;

    if (j == 0) begin : g_first
      // Quotients of 2^QW or more always clamp to the last column or row
      assign rc_in = s2_q.pc;
      assign rr_in = s2_q.pr;
      assign qc_in = '0;
      assign qr_in = '0;
      always_comb begin
        side_d.bad   = s2_q.bad;
        side_d.pad   = s2_q.pad;
        side_d.ovf_c = s2_q.pc >= (PW'(geo.num) << QW);
        side_d.ovf_r = s2_q.pr >= (PW'(geo.num) << QW);
        side_d.doff  = '0;
      end
      always_ff @(posedge clk_i) begin
        if (ld[SD0]) dsum_q <= s2_q.dprod + PW'(s2_q.col);
      end
    end else begin : g_next
      assign rc_in = dv_rc_q[j-1];
      assign rr_in = dv_rr_q[j-1];
      assign qc_in = dv_qc_q[j-1];
      assign qr_in = dv_qr_q[j-1];
      if (j == 1) begin : g_doff
        // Scale the destination pixel index by bytes per pixel
        always_comb begin
          logic [PW+BppW-1:0] full;
          full        = (PW+BppW)'(dsum_q) * (PW+BppW)'(geo.bpp);
          side_d      = dv_side_q[j-1];
          side_d.doff = full[OffW-1:0];
        end
      end else begin : g_carry
        assign side_d = dv_side_q[j-1];
      end
    end

    lbr_div_stage #(
      .Steps  (DivBits),
      .TopBit (Top)
    ) u_col (
      .divisor_i (geo.num),
      .rem_i     (rc_in),
      .quo_i     (qc_in),
      .rem_o     (rc_out),
      .quo_o     (qc_out)
    );

    lbr_div_stage #(
      .Steps  (DivBits),
      .TopBit (Top)
    ) u_row (
      .divisor_i (geo.num),
      .rem_i     (rr_in),
      .quo_i     (qr_in),
      .rem_o     (rr_out),
      .quo_o     (qr_out)
    );

    always_ff @(posedge clk_i) begin
      if (ld[SD0+j]) begin
        dv_rc_q[j]   <= rc_out;
        dv_rr_q[j]   <= rr_out;
        dv_qc_q[j]   <= qc_out;
        dv_qr_q[j]   <= qr_out;
        dv_side_q[j] <= side_d;
      end
    end
  end

  // Clamp stage: limit to the last source column and row
  always_comb begin
    logic [DimW-1:0] lastc, lastr;
    side_t           sd;
    sd    = dv_side_q[ND-1];
    lastc = geo.sw - 1'b1;
    lastr = geo.sh - 1'b1;
    cl_d.bad  = sd.bad;
    cl_d.pad  = sd.pad;
    cl_d.doff = sd.doff;
    cl_d.scol = (sd.ovf_c || (dv_qc_q[ND-1] > lastc)) ? lastc : dv_qc_q[ND-1];
    cl_d.srow = (sd.ovf_r || (dv_qr_q[ND-1] > lastr)) ? lastr : dv_qr_q[ND-1];
  end

  always_ff @(posedge clk_i) begin
    if (ld[SCL]) cl_q <= cl_d;
  end

  // Source row product
  always_ff @(posedge clk_i) begin
    if (ld[SM]) begin
      sm_q.bad   <= cl_q.bad;
      sm_q.pad   <= cl_q.pad;
      sm_q.scol  <= cl_q.scol;
      sm_q.doff  <= cl_q.doff;
      sm_q.sprod <= PW'(cl_q.srow) * PW'(geo.sw);
    end
  end

  // Add the source column
  always_ff @(posedge clk_i) begin
    if (ld[SA]) begin
      sa_q.bad  <= sm_q.bad;
      sa_q.pad  <= sm_q.pad;
      sa_q.scol <= sm_q.scol;
      sa_q.doff <= sm_q.doff;
      sa_q.ssum <= (PW+1)'(sm_q.sprod) + (PW+1)'(sm_q.scol);
    end
  end

  // Carry the clamped source row alongside the offset math
  always_ff @(posedge clk_i) begin
    if (ld[SM]) srow_m_q <= cl_q.srow;
    if (ld[SA]) srow_a_q <= srow_m_q;
  end

  // Output stage: scale to bytes, zero fields of padding and bad coordinates
  always_comb begin
    logic [PW+BppW:0] full;
    logic             zero;
    full = (PW+BppW+1)'(sa_q.ssum) * (PW+BppW+1)'(geo.bpp);
    zero = sa_q.pad || sa_q.bad;
    so_d.bad  = sa_q.bad;
    so_d.pad  = sa_q.pad;
    so_d.scol = zero ? '0 : sa_q.scol;
    so_d.srow = zero ? '0 : srow_a_q;
    so_d.soff = zero ? '0 : full[OffW-1:0];
    so_d.doff = sa_q.bad ? '0 : sa_q.doff;
  end

  always_ff @(posedge clk_i) begin
    if (ld[SO]) so_q <= so_d;
  end

  // Drive the result channel
  assign res_o.valid          = v_q[SO];
  assign res_o.is_pad         = so_q.pad;
  assign res_o.bad_coord      = so_q.bad;
  assign res_o.source_col     = so_q.scol[CoordW-1:0];
  assign res_o.source_row     = so_q.srow[CoordW-1:0];
  assign res_o.source_offset  = so_q.soff;
  assign res_o.dest_offset    = so_q.doff;
  assign res_o.pad_left       = geo.padl[lbr_pkg::PadW-1:0];
  assign res_o.pad_top        = geo.padt[lbr_pkg::PadW-1:0];
  assign res_o.content_width  = geo.cw;
  assign res_o.content_height = geo.ch;
  assign res_o.ratio_num      = geo.num;
  assign res_o.ratio_den      = geo.den;

`ifndef SYNTHESIS
  a_pad_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.is_pad && res_o.bad_coord))
    else $error("item flagged both padding and out of frame");

  a_scol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SO] |-> (so_q.scol < geo.sw) && (so_q.srow < geo.sh))
    else $error("source coordinate beyond the last column or row");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |=> v_q[S1])
    else $error("accepted item did not enter the first stage");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the letterbox resize address generator. A directed
// plan walks the register and coordinate extremes, then random register
// settings each carry a burst of destination coordinates. Every result is
// compared field by field against typed plan values or an in-bench address
// calculator, with random idle bursts on the coordinate and result channels.
// ----------------------------------------------------------------------------
module testbench;
  import lbr_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned SettleLimit = 30;
  localparam int unsigned PlanRows    = 36;

  // Expected result of one destination coordinate
  typedef struct packed {
    logic              is_pad;
    logic              bad_coord;
    logic [CoordW-1:0] source_col;
    logic [CoordW-1:0] source_row;
    logic [OffW-1:0]   source_offset;
    logic [OffW-1:0]   dest_offset;
    logic [PadW-1:0]   pad_left;
    logic [PadW-1:0]   pad_top;
    logic [DimW-1:0]   content_width;
    logic [DimW-1:0]   content_height;
    logic [DimW-1:0]   ratio_num;
    logic [DimW-1:0]   ratio_den;
  } addr_res_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } plan_kind_e;

  // One step of the directed plan: a register write or a coordinate
  typedef struct packed {
    plan_kind_e          kind;
    logic                typed;
    lbr_reg_e            reg_idx;
    logic [CfgDataW-1:0] data;
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   row;
    addr_res_t           want;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lbr_cfg_if cfg_ch ();
  lbr_in_if  pix_ch ();
  lbr_out_if res_ch ();

  // Register copies as the block sees them
  logic [DimW-1:0] frame_src_w = RstSrcW;
  logic [DimW-1:0] frame_src_h = RstSrcH;
  logic [DimW-1:0] frame_dst_w = RstDstW;
  logic [DimW-1:0] frame_dst_h = RstDstH;
  logic [BppW-1:0] frame_bpp   = RstBpp;

  addr_res_t   addr_q [$];
  addr_res_t   typed_result = '0;
  bit          want_typed   = 1'b0;
  bit          bursts_on    = 1'b1;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;

  // Directed plan: default geometry, then clamped and extreme geometries
  plan_row_t directed_plan [PlanRows] = '{
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd0, 12'd0,
      '{1'b1, 1'b0, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd140, 13'd640, 13'd360, 13'd640, 13'd1920}},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd4095, 12'd4095,
      '{1'b0, 1'b1, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd140, 13'd640, 13'd360, 13'd640, 13'd1920}},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd639, 12'd639,
      '{1'b1, 1'b0, 12'd0, 12'd0, 26'd0, 26'd1228797,
        11'd0, 11'd140, 13'd640, 13'd360, 13'd640, 13'd1920}},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd0, 12'd140,
      '{1'b0, 1'b0, 12'd0, 12'd0, 26'd0, 26'd268800,
        11'd0, 11'd140, 13'd640, 13'd360, 13'd640, 13'd1920}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd639, 12'd499, '0},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd640, 12'd0,
      '{1'b0, 1'b1, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd140, 13'd640, 13'd360, 13'd640, 13'd1920}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd0, 12'd640, '0},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd320, 12'd320, '0},
    // zero and oversized registers fall back to their limits
    '{ROW_CFG, 1'b0, REG_SRC_W, 13'd0, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_SRC_H, 13'd0, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_W, 13'd8191, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_H, 13'd4096, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_BPP, 13'd0, 12'd0, 12'd0, '0},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd0, 12'd0,
      '{1'b0, 1'b0, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd0, 13'd4096, 13'd4096, 13'd4096, 13'd1}},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd4095, 12'd4095,
      '{1'b0, 1'b0, 12'd0, 12'd0, 26'd0, 26'd16777215,
        11'd0, 11'd0, 13'd4096, 13'd4096, 13'd4096, 13'd1}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd2048, 12'd1, '0},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd2730, 12'd1365, '0},
    // one-pixel target from the largest source
    '{ROW_CFG, 1'b0, REG_SRC_W, 13'd8191, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_SRC_H, 13'd4096, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_W, 13'd1, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_H, 13'd1, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_BPP, 13'd7, 12'd0, 12'd0, '0},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd0, 12'd0,
      '{1'b0, 1'b0, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd0, 13'd1, 13'd1, 13'd1, 13'd4096}},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd1, 12'd0,
      '{1'b0, 1'b1, 12'd0, 12'd0, 26'd0, 26'd0,
        11'd0, 11'd0, 13'd1, 13'd1, 13'd1, 13'd4096}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd0, 12'd4095, '0},
    // one-row content: widest top pad
    '{ROW_CFG, 1'b0, REG_SRC_H, 13'd1, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_W, 13'd4096, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_DST_H, 13'd4096, 12'd0, 12'd0, '0},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd4095, 12'd2047,
      '{1'b0, 1'b0, 12'd4095, 12'd0, 26'd16380, 26'd33554428,
        11'd0, 11'd2047, 13'd4096, 13'd1, 13'd4096, 13'd4096}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd4095, 12'd2048, '0},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd0, 12'd2046, '0},
    // one-column content: widest left pad
    '{ROW_CFG, 1'b0, REG_SRC_W, 13'd1, 12'd0, 12'd0, '0},
    '{ROW_CFG, 1'b0, REG_SRC_H, 13'd4096, 12'd0, 12'd0, '0},
    '{ROW_PIX, 1'b1, REG_SRC_W, 13'd0, 12'd2047, 12'd4095,
      '{1'b0, 1'b0, 12'd0, 12'd4095, 26'd16380, 26'd67100668,
        11'd2047, 11'd0, 13'd1, 13'd4096, 13'd4096, 13'd4096}},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd2046, 12'd0, '0},
    '{ROW_PIX, 1'b0, REG_SRC_W, 13'd0, 12'd2048, 12'd0, '0}
  };

  letterbox_resize_address_gen i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .pix_i  (pix_ch),
    .res_o  (res_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Letterbox geometry and nearest-neighbor addresses of one coordinate
  function automatic addr_res_t letterbox_address(logic [CoordW-1:0] col_in,
                                                  logic [CoordW-1:0] row_in);
    longint unsigned sw, sh, tw, th, bpp, col, row;
    longint unsigned num, den, cw, ch, padl, padt, scol, srow;
    addr_res_t r;
    sw  = clamp_to(64'(frame_src_w), 64'(MaxDim));
    sh  = clamp_to(64'(frame_src_h), 64'(MaxDim));
    tw  = clamp_to(64'(frame_dst_w), 64'(MaxDim));
    th  = clamp_to(64'(frame_dst_h), 64'(MaxDim));
    bpp = clamp_to(64'(frame_bpp), 64'(MaxChannels));
    col = 64'(col_in);
    row = 64'(row_in);
    // pick the tighter axis as the scale
    if (tw * sh < th * sw) begin
      num = tw;
      den = sw;
    end else begin
      num = th;
      den = sh;
    end
    cw = (sw * num) / den;
    ch = (sh * num) / den;
    if (cw > tw) cw = tw;
    if (ch > th) ch = th;
    padl = (tw - cw) / 2;
    padt = (th - ch) / 2;

    r = '0;
    r.pad_left       = PadW'(padl);
    r.pad_top        = PadW'(padt);
    r.content_width  = DimW'(cw);
    r.content_height = DimW'(ch);
    r.ratio_num      = DimW'(num);
    r.ratio_den      = DimW'(den);
    if (col >= tw || row >= th) begin
      r.bad_coord = 1'b1;
    end else begin
      r.dest_offset = OffW'((row * tw + col) * bpp);
      if (col < padl || col >= padl + cw || row < padt || row >= padt + ch) begin
        r.is_pad = 1'b1;
      end else begin
        scol = ((col - padl) * den) / num;
        srow = ((row - padt) * den) / num;
        if (scol > sw - 1) scol = sw - 1;
        if (srow > sh - 1) srow = sh - 1;
        r.source_col    = CoordW'(scol);
        r.source_row    = CoordW'(srow);
        r.source_offset = OffW'((srow * sw + scol) * bpp);
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(addr_res_t want, addr_res_t got);
    check_field("is_pad", 32'(want.is_pad), 32'(got.is_pad));
    check_field("bad_coord", 32'(want.bad_coord), 32'(got.bad_coord));
    check_field("source_col", 32'(want.source_col), 32'(got.source_col));
    check_field("source_row", 32'(want.source_row), 32'(got.source_row));
    check_field("source_offset", 32'(want.source_offset), 32'(got.source_offset));
    check_field("dest_offset", 32'(want.dest_offset), 32'(got.dest_offset));
    check_field("pad_left", 32'(want.pad_left), 32'(got.pad_left));
    check_field("pad_top", 32'(want.pad_top), 32'(got.pad_top));
    check_field("content_width", 32'(want.content_width), 32'(got.content_width));
    check_field("content_height", 32'(want.content_height), 32'(got.content_height));
    check_field("ratio_num", 32'(want.ratio_num), 32'(got.ratio_num));
    check_field("ratio_den", 32'(want.ratio_den), 32'(got.ratio_den));
  endfunction

  // Register value: often small frames, sometimes the extremes
  function automatic logic [CfgDataW-1:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return CfgDataW'(MaxDim);
    if (pick == 3) return CfgDataW'($urandom_range(0, 8191));
    if (pick < 10) return CfgDataW'($urandom_range(1, 48));
    return CfgDataW'($urandom_range(1, MaxDim));
  endfunction

  // Coordinate aimed at the frame, the content borders or anywhere
  function automatic void random_pixel(output logic [CoordW-1:0] col,
                                       output logic [CoordW-1:0] row);
    addr_res_t   geo;
    int unsigned tw, th, pick, base_c, base_r;
    geo  = letterbox_address('0, '0);
    tw   = 32'(clamp_to(64'(frame_dst_w), 64'(MaxDim)));
    th   = 32'(clamp_to(64'(frame_dst_h), 64'(MaxDim)));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      col = CoordW'($urandom_range(0, tw - 1));
      row = CoordW'($urandom_range(0, th - 1));
    end else if (pick < 70) begin
      base_c = 32'(geo.pad_left);
      base_r = 32'(geo.pad_top);
      if ($urandom_range(0, 1) != 0) base_c = base_c + 32'(geo.content_width);
      if ($urandom_range(0, 1) != 0) base_r = base_r + 32'(geo.content_height);
      col = CoordW'(base_c + $urandom_range(0, 3) - 2);
      row = CoordW'(base_r + $urandom_range(0, 3) - 2);
    end else if (pick < 85) begin
      col = CoordW'(tw - 1 + $urandom_range(0, 1));
      row = CoordW'($urandom_range(0, 1) != 0 ? th - 1 + $urandom_range(0, 1)
                                               : $urandom_range(0, th - 1));
    end else begin
      col = CoordW'($urandom_range(0, 4095));
      row = CoordW'($urandom_range(0, 4095));
    end
  endfunction

  // Hold coordinates off until every expected result has come back
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (addr_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(lbr_reg_e idx, logic [CfgDataW-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(negedge clk_i);
    while (!cfg_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_pix(logic [CoordW-1:0] col, logic [CoordW-1:0] row);
    cfg_ch.valid    <= 1'b0;
    pix_ch.valid    <= 1'b1;
    pix_ch.dest_col <= col;
    pix_ch.dest_row <= row;
    @(negedge clk_i);
    while (!pix_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic pix_gap();
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Result side: ready in random bursts
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (bursts_on && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Observe handshakes on the falling edge before the rising edge that takes them
  always @(negedge clk_i) begin
    addr_res_t got;
    if (rst_ni) begin
      quiet_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        quiet_cycles       = 0;
        got.is_pad         = res_ch.is_pad;
        got.bad_coord      = res_ch.bad_coord;
        got.source_col     = res_ch.source_col;
        got.source_row     = res_ch.source_row;
        got.source_offset  = res_ch.source_offset;
        got.dest_offset    = res_ch.dest_offset;
        got.pad_left       = res_ch.pad_left;
        got.pad_top        = res_ch.pad_top;
        got.content_width  = res_ch.content_width;
        got.content_height = res_ch.content_height;
        got.ratio_num      = res_ch.ratio_num;
        got.ratio_den      = res_ch.ratio_den;
        if (addr_q.size() == 0) begin
          $display("%0t result with nothing expected: expected none, got %h", $time, got);
          mismatches++;
        end else begin
          compare_result(addr_q.pop_front(), got);
        end
      end
      if (pix_ch.valid && pix_ch.ready) begin
        quiet_cycles = 0;
        addr_q.push_back(want_typed ? typed_result
                                    : letterbox_address(pix_ch.dest_col, pix_ch.dest_row));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        quiet_cycles = 0;
        case (cfg_ch.index)
          REG_SRC_W: frame_src_w = cfg_ch.data;
          REG_SRC_H: frame_src_h = cfg_ch.data;
          REG_DST_W: frame_dst_w = cfg_ch.data;
          REG_DST_H: frame_dst_h = cfg_ch.data;
          REG_BPP:   frame_bpp   = BppW'(cfg_ch.data);
          default: ;
        endcase
      end
    end
  end

  // Watchdog: stop when nothing has moved for too long
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("letterbox_resize_address_gen regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CoordW-1:0] col, row;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_SRC_W;
    cfg_ch.data     <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.dest_col <= '0;
    pix_ch.dest_row <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_reg(directed_plan[i].reg_idx, directed_plan[i].data);
      end else begin
        want_typed   = directed_plan[i].typed;
        typed_result = directed_plan[i].want;
        send_pix(directed_plan[i].col, directed_plan[i].row);
        pix_gap();
      end
    end
    want_typed = 1'b0;

    // random geometries, each with a burst of coordinates; calm tail
    for (int p = 0; p < RandPhases; p++) begin
      bursts_on = (p < RandPhases - 3) && ($urandom_range(0, 3) != 0);
      write_reg(REG_SRC_W, pick_dim());
      write_reg(REG_SRC_H, pick_dim());
      write_reg(REG_DST_W, pick_dim());
      write_reg(REG_DST_H, pick_dim());
      write_reg(REG_BPP, CfgDataW'($urandom_range(0, 7)));
      for (int n = 0; n < PhaseItems; n++) begin
        random_pixel(col, row);
        send_pix(col, row);
        pix_gap();
      end
    end

    drain();
    repeat (SettleLimit) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("letterbox_resize_address_gen regression: pass");
    end else begin
      $display("letterbox_resize_address_gen regression: fail");
    end
    $finish;
  end

endmodule
